// ===== design/adpr_pkg.sv =====
// Shared types, constants, width helpers and control store of the drift pitch regulator.
package adpr_pkg;

    // Fixed-point and timing constants
    localparam int FILL_FRAC = 16;       // fraction bits of the smoothed queue fill
    localparam int DT_W      = 17;       // width of the clamped elapsed time
    localparam int ELAP_W    = 20;       // width of the elapsed time field
    localparam int DT_MAX    = 100000;   // elapsed time clamp, us
    localparam int FILL_TAU  = 500000;   // fill filter time constant, us
    localparam int PITCH_TAU = 1000000;  // pitch filter time constant, us
    localparam int TAU_W     = 21;       // width of tau + dt

    // Configuration register indexes
    localparam int              CFG_IDX_W        = 2;
    localparam [CFG_IDX_W-1:0]  CFG_RATE_RATIO   = 2'd0;
    localparam [CFG_IDX_W-1:0]  CFG_QUEUE_TARGET = 2'd1;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_FILL_SET,
        OP_MUL,
        OP_DIV,
        OP_FILL_UPD,
        OP_CORR_SET,
        OP_DES_SET,
        OP_ROUND,
        OP_PITCH_SET,
        OP_PITCH_UPD,
        OP_EMIT
    } t_dp_op;

    // Step counter actions
    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_DEC,
        CNT_DT,
        CNT_FRAC,
        CNT_DIV
    } t_cnt_sel;

    // Sequencer branch conditions
    typedef enum logic [2:0] {
        J_SEQ,
        J_LOOP,
        J_WAIT_IN,
        J_WAIT_OUT,
        J_GOTO
    } t_jcond;

    typedef logic [4:0] t_upc;

    // Program addresses
    localparam t_upc PC_IDLE  = 5'd0;
    localparam t_upc PC_F_SET = 5'd1;
    localparam t_upc PC_F_MUL = 5'd2;
    localparam t_upc PC_F_DVI = 5'd3;
    localparam t_upc PC_F_DIV = 5'd4;
    localparam t_upc PC_F_UPD = 5'd5;
    localparam t_upc PC_C_SET = 5'd6;
    localparam t_upc PC_C_DIV = 5'd7;
    localparam t_upc PC_D_SET = 5'd8;
    localparam t_upc PC_D_MUL = 5'd9;
    localparam t_upc PC_D_RND = 5'd10;
    localparam t_upc PC_P_SET = 5'd11;
    localparam t_upc PC_P_MUL = 5'd12;
    localparam t_upc PC_P_DVI = 5'd13;
    localparam t_upc PC_P_DIV = 5'd14;
    localparam t_upc PC_P_UPD = 5'd15;
    localparam t_upc PC_EMIT  = 5'd16;

    // One control word
    typedef struct packed {
        t_dp_op   op;
        t_cnt_sel cnt;
        t_jcond   jc;
        t_upc     tgt;
    } t_uop;

    // Control from the sequencer to the datapath
    typedef struct packed {
        t_dp_op               op;
        logic                 cfg_we;
        logic [CFG_IDX_W-1:0] cfg_idx;
    } t_dp_ctrl;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Working accumulator width: covers every product and dividend
    function automatic int f_acc_w(input int qb, input int fb);
        int ws;
        int up;
        ws = qb + FILL_FRAC;
        up = (fb >= FILL_FRAC) ? fb - FILL_FRAC : 0;
        return f_max(f_max(ws + DT_W, ws + up), f_max(2 * fb + 2, fb + 1 + DT_W));
    endfunction

    // Divisor width: tau + dt or 100 * target scaled to the pitch fraction
    function automatic int f_div_w(input int qb, input int fb);
        int down;
        down = (fb < FILL_FRAC) ? FILL_FRAC - fb : 0;
        return f_max(TAU_W, qb + 7 + down);
    endfunction

    function automatic int f_cfg_w(input int qb, input int fb);
        return f_max(fb + 1, qb);
    endfunction

    // Control store
    function automatic t_uop f_ucode(input t_upc pc);
        t_uop u;
        u = '{op: OP_NOP, cnt: CNT_HOLD, jc: J_SEQ, tgt: PC_IDLE};
        case (pc)
            PC_IDLE: begin
                u.op = OP_CAPTURE;
                u.jc = J_WAIT_IN;
            end
            PC_F_SET: begin
                u.op  = OP_FILL_SET;
                u.cnt = CNT_DT;
            end
            PC_F_MUL, PC_D_MUL, PC_P_MUL: begin
                u.op  = OP_MUL;
                u.cnt = CNT_DEC;
                u.jc  = J_LOOP;
            end
            PC_F_DVI, PC_P_DVI: begin
                u.cnt = CNT_DIV;
            end
            PC_F_DIV, PC_C_DIV, PC_P_DIV: begin
                u.op  = OP_DIV;
                u.cnt = CNT_DEC;
                u.jc  = J_LOOP;
            end
            PC_F_UPD: begin
                u.op = OP_FILL_UPD;
            end
            PC_C_SET: begin
                u.op  = OP_CORR_SET;
                u.cnt = CNT_DIV;
            end
            PC_D_SET: begin
                u.op  = OP_DES_SET;
                u.cnt = CNT_FRAC;
            end
            PC_D_RND: begin
                u.op = OP_ROUND;
            end
            PC_P_SET: begin
                u.op  = OP_PITCH_SET;
                u.cnt = CNT_DT;
            end
            PC_P_UPD: begin
                u.op = OP_PITCH_UPD;
            end
            PC_EMIT: begin
                u.op  = OP_EMIT;
                u.jc  = J_WAIT_OUT;
                u.tgt = PC_IDLE;
            end
            default: begin
                u.jc  = J_GOTO;
                u.tgt = PC_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

// ===== design/audio_drift_pitch_regulator_core.sv =====
// Top level: microcoded sequencer, handshakes and result register of the drift pitch regulator.
// One transaction at a time; the result register loads once the bit-serial multiply and divide
// loops of the control program have run (ACC_W = 49 at the default widths) and the output is not
// stalled. The next transaction is taken the cycle after the result is loaded, while that
// result may still wait.
// Synchronous active-low reset returns the sequencer to idle, empties the output and loads
// rate_ratio = 1.0, queue_target = 2048 and the matching filter state.
module audio_drift_pitch_regulator_core import adpr_pkg::*; #(
    parameter int QUEUE_BITS = 16,
    parameter int FRAC_BITS  = 20
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]                       i_cfg_idx,
    input  logic [f_cfg_w(QUEUE_BITS, FRAC_BITS)-1:0]  i_cfg_wdata,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic [QUEUE_BITS-1:0]                      i_queue_fill,
    input  logic [ELAP_W-1:0]                          i_elapsed_us,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic [FRAC_BITS:0]                         o_pitch
);

    localparam int ACC_W = f_acc_w(QUEUE_BITS, FRAC_BITS);
    localparam int CNT_W = $clog2(ACC_W);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_upc             r_pc;
    t_upc             n_pc;
    logic             r_out_valid;
    logic [FRAC_BITS:0] r_out_pitch;

    t_uop             uop;
    t_dp_ctrl         dp_ctrl;
    logic             in_fire;
    logic             out_busy;
    logic             emit;
    logic [FRAC_BITS:0] dp_pitch;

    // Fetch the control word
    assign uop      = f_ucode(r_pc);
    assign o_in_ready = (r_pc == PC_IDLE);
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_busy = r_out_valid && !i_out_ready;
    assign emit     = (uop.op == OP_EMIT) && !out_busy;

    // Drive the datapath; capture only on an accepted transaction
    always_comb begin
        dp_ctrl.op      = (uop.op == OP_CAPTURE && !in_fire) ? OP_NOP : uop.op;
        dp_ctrl.cfg_we  = i_cfg_wen;
        dp_ctrl.cfg_idx = i_cfg_idx;
    end

    // Next step and step counter
    always_comb begin
        case (uop.jc)
            J_SEQ:      n_pc = r_pc + 1'b1;
            J_LOOP:     n_pc = (r_cnt != '0) ? r_pc : r_pc + 1'b1;
            J_WAIT_IN:  n_pc = in_fire ? r_pc + 1'b1 : r_pc;
            J_WAIT_OUT: n_pc = out_busy ? r_pc : uop.tgt;
            J_GOTO:     n_pc = uop.tgt;
            default:    n_pc = PC_IDLE;
        endcase

        case (uop.cnt)
            CNT_DEC:  n_cnt = (r_cnt != '0) ? r_cnt - 1'b1 : r_cnt;
            CNT_DT:   n_cnt = CNT_W'(DT_W - 1);
            CNT_FRAC: n_cnt = CNT_W'(FRAC_BITS);
            CNT_DIV:  n_cnt = CNT_W'(ACC_W - 1);
            default:  n_cnt = r_cnt;
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_IDLE;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_pitch <= dp_pitch;
        end
    end

    adpr_datapath #(
        .QUEUE_BITS (QUEUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (dp_ctrl),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_queue_fill (i_queue_fill),
        .i_elapsed_us (i_elapsed_us),
        .o_pitch      (dp_pitch)
    );

    assign o_out_valid = r_out_valid;
    assign o_pitch     = r_out_pitch;

endmodule

// ===== design/adpr_datapath.sv =====
// Arithmetic datapath: config and filter state, shift-add multiplier, restoring divider.
module adpr_datapath import adpr_pkg::*; #(
    parameter int QUEUE_BITS = 16,
    parameter int FRAC_BITS  = 20
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  t_dp_ctrl                                   i_ctrl,
    input  logic [f_cfg_w(QUEUE_BITS, FRAC_BITS)-1:0]  i_cfg_wdata,
    input  logic [QUEUE_BITS-1:0]                      i_queue_fill,
    input  logic [ELAP_W-1:0]                          i_elapsed_us,
    output logic [FRAC_BITS:0]                         o_pitch
);

    localparam int W_S    = QUEUE_BITS + FILL_FRAC;
    localparam int W_P    = FRAC_BITS + 1;
    localparam int UP     = (FRAC_BITS >= FILL_FRAC) ? FRAC_BITS - FILL_FRAC : 0;
    localparam int DOWN   = (FRAC_BITS < FILL_FRAC) ? FILL_FRAC - FRAC_BITS : 0;
    localparam int ACC_W  = f_acc_w(QUEUE_BITS, FRAC_BITS);
    localparam int DIV_W  = f_div_w(QUEUE_BITS, FRAC_BITS);
    localparam int MC_W   = f_max(W_S, W_P);
    localparam int MLT_W  = f_max(DT_W, W_P);
    localparam int T100_W = QUEUE_BITS + 7;
    localparam int LIM    = ((1 << FRAC_BITS) + 100) / 200;

    localparam logic [W_P-1:0]        ONE_FX      = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [QUEUE_BITS-1:0] TARGET_RST  = QUEUE_BITS'(2048);
    localparam logic [QUEUE_BITS-1:0] TGT_EFF_RST =
        (TARGET_RST == '0) ? QUEUE_BITS'(1) : TARGET_RST;
    localparam logic [W_S-1:0]        SMOOTH_RST  = {TGT_EFF_RST, {FILL_FRAC{1'b0}}};

    // Configuration and filter state
    logic [W_P-1:0]        r_rate;
    logic [QUEUE_BITS-1:0] r_target;
    logic [W_S-1:0]        r_smooth;
    logic [W_P-1:0]        r_pitch;

    // Working registers
    logic [QUEUE_BITS-1:0] r_fill;
    logic [DT_W-1:0]       r_dt;
    logic                  r_neg;
    logic [ACC_W-1:0]      r_acc;
    logic [DIV_W-1:0]      r_rem;
    logic [DIV_W-1:0]      r_dvs;
    logic [MC_W-1:0]       r_mcand;
    logic [MLT_W-1:0]      r_mlt;

    logic [QUEUE_BITS-1:0] t_eff;
    logic [QUEUE_BITS-1:0] cfg_tgt;
    logic [QUEUE_BITS-1:0] cfg_tgt_eff;
    logic [W_S-1:0]        tfx;
    logic [W_S-1:0]        fill_goal;
    logic                  f_neg;
    logic [W_S-1:0]        f_diff;
    logic                  c_neg;
    logic [W_S-1:0]        c_mag;
    logic [T100_W-1:0]     t_x100;
    logic [ACC_W-1:0]      mul_sum;
    logic [DIV_W:0]        rem_sh;
    logic [DIV_W:0]        rem_sub;
    logic                  div_ge;
    logic [FRAC_BITS-1:0]  corr;
    logic [W_P-1:0]        factor;
    logic [ACC_W-1:0]      rnd_sum;
    logic [ACC_W-1:0]      rnd_sh;
    logic [W_P-1:0]        desired;
    logic [W_P-1:0]        p_goal;
    logic                  p_neg;
    logic [W_P-1:0]        p_diff;
    logic [DT_W-1:0]       dt_clamp;

    // Operand preparation and the one-bit multiply and divide steps
    always_comb begin
        t_eff       = (r_target == '0) ? QUEUE_BITS'(1) : r_target;
        cfg_tgt     = i_cfg_wdata[QUEUE_BITS-1:0];
        cfg_tgt_eff = (cfg_tgt == '0) ? QUEUE_BITS'(1) : cfg_tgt;
        tfx         = {t_eff, {FILL_FRAC{1'b0}}};
        fill_goal   = {r_fill, {FILL_FRAC{1'b0}}};

        f_neg  = fill_goal < r_smooth;
        f_diff = f_neg ? r_smooth - fill_goal : fill_goal - r_smooth;

        c_neg  = r_smooth < tfx;
        c_mag  = c_neg ? tfx - r_smooth : r_smooth - tfx;
        t_x100 = T100_W'(t_eff) * T100_W'(100);

        mul_sum = (r_acc << 1) + (r_mlt[MLT_W-1] ? ACC_W'(r_mcand) : '0);

        rem_sh  = {r_rem, r_acc[ACC_W-1]};
        div_ge  = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};

        corr   = (r_acc > ACC_W'(LIM)) ? FRAC_BITS'(LIM) : r_acc[FRAC_BITS-1:0];
        factor = r_neg ? ONE_FX - W_P'(corr) : ONE_FX + W_P'(corr);

        rnd_sum = r_acc + (ACC_W'(1) << (FRAC_BITS - 1));
        rnd_sh  = rnd_sum >> FRAC_BITS;
        desired = (|rnd_sh[ACC_W-1:W_P]) ? '1 : rnd_sh[W_P-1:0];

        p_goal = r_acc[W_P-1:0];
        p_neg  = p_goal < r_pitch;
        p_diff = p_neg ? r_pitch - p_goal : p_goal - r_pitch;

        dt_clamp = (i_elapsed_us > ELAP_W'(DT_MAX)) ? DT_W'(DT_MAX) : i_elapsed_us[DT_W-1:0];
    end

    // Hold configuration and filter state; reload on a configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= ONE_FX;
            r_target <= TARGET_RST;
            r_smooth <= SMOOTH_RST;
            r_pitch  <= ONE_FX;
        end else if (i_ctrl.cfg_we && i_ctrl.cfg_idx == CFG_RATE_RATIO) begin
            r_rate   <= i_cfg_wdata[W_P-1:0];
            r_pitch  <= i_cfg_wdata[W_P-1:0];
            r_smooth <= tfx;
        end else if (i_ctrl.cfg_we && i_ctrl.cfg_idx == CFG_QUEUE_TARGET) begin
            r_target <= cfg_tgt;
            r_smooth <= {cfg_tgt_eff, {FILL_FRAC{1'b0}}};
            r_pitch  <= r_rate;
        end else begin
            case (i_ctrl.op)
                OP_FILL_UPD: begin
                    r_smooth <= r_neg ? r_smooth - r_acc[W_S-1:0]
                                      : r_smooth + r_acc[W_S-1:0];
                end
                OP_PITCH_UPD: begin
                    r_pitch <= r_neg ? r_pitch - r_acc[W_P-1:0]
                                     : r_pitch + r_acc[W_P-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Execute the datapath operation of the current step
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_CAPTURE: begin
                r_fill <= i_queue_fill;
                r_dt   <= dt_clamp;
            end
            OP_FILL_SET: begin
                r_neg   <= f_neg;
                r_mcand <= MC_W'(f_diff);
                r_mlt   <= MLT_W'(r_dt) << (MLT_W - DT_W);
                r_acc   <= '0;
                r_rem   <= '0;
                r_dvs   <= DIV_W'(FILL_TAU) + DIV_W'(r_dt);
            end
            OP_MUL: begin
                r_acc <= mul_sum;
                r_mlt <= r_mlt << 1;
            end
            OP_DIV: begin
                r_rem <= div_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
                r_acc <= {r_acc[ACC_W-2:0], div_ge};
            end
            OP_CORR_SET: begin
                r_neg <= c_neg;
                r_acc <= ACC_W'(c_mag) << UP;
                r_rem <= '0;
                r_dvs <= DIV_W'(t_x100) << DOWN;
            end
            OP_DES_SET: begin
                r_mlt   <= MLT_W'(factor) << (MLT_W - W_P);
                r_mcand <= MC_W'(r_rate);
                r_acc   <= '0;
            end
            OP_ROUND: begin
                r_acc <= ACC_W'(desired);
            end
            OP_PITCH_SET: begin
                r_neg   <= p_neg;
                r_mcand <= MC_W'(p_diff);
                r_mlt   <= MLT_W'(r_dt) << (MLT_W - DT_W);
                r_acc   <= '0;
                r_rem   <= '0;
                r_dvs   <= DIV_W'(PITCH_TAU) + DIV_W'(r_dt);
            end
            default: begin
            end
        endcase
    end

    assign o_pitch = r_pitch;

endmodule

// ===== design/adpr_checker.sv =====
// Port-level checker of the drift pitch regulator and its bind to the top level.
module adpr_checker #(
    parameter int FRAC_BITS = 20
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [FRAC_BITS:0] o_pitch
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pitch))
        else $error("result changed or dropped while stalled");

    // An accepted transaction occupies the block
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input still ready after an accepted transaction");

    // The block frees up only by delivering a result
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_ready) && $past(i_rst_n) |-> o_out_valid)
        else $error("input ready returned without a result");

    // A new result appears only at the end of a transaction's work
    a_result_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && $past(i_rst_n) |-> $past(!o_in_ready) && o_in_ready)
        else $error("result appeared while idle");

endmodule

bind audio_drift_pitch_regulator_core adpr_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_adpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pitch     (o_pitch)
);

// ===== tb/adpr_pitch_checker.sv =====
// Checker for the drift pitch regulator: tracks config writes, predicts each pitch, compares results.
`timescale 1ns / 100ps

module adpr_pitch_checker import adpr_pkg::*; #(
    parameter int QUEUE_BITS = 16,
    parameter int FRAC_BITS  = 20
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]                       i_cfg_idx,
    input  logic [f_cfg_w(QUEUE_BITS, FRAC_BITS)-1:0]  i_cfg_wdata,
    input  logic                                       i_in_valid,
    input  logic                                       i_in_ready,
    input  logic [QUEUE_BITS-1:0]                      i_queue_fill,
    input  logic [ELAP_W-1:0]                          i_elapsed_us,
    input  logic                                       i_out_valid,
    input  logic                                       i_out_ready,
    input  logic [FRAC_BITS:0]                         i_pitch,
    output int                                         o_mismatches,
    output int                                         o_backlog
);

    localparam int          UP        = (FRAC_BITS >= FILL_FRAC) ? FRAC_BITS - FILL_FRAC : 0;
    localparam int          DOWN      = (FRAC_BITS < FILL_FRAC) ? FILL_FRAC - FRAC_BITS : 0;
    localparam logic [63:0] ONE       = 64'd1 << FRAC_BITS;
    localparam logic [63:0] PITCH_MAX = (64'd1 << (FRAC_BITS + 1)) - 64'd1;
    localparam logic [63:0] CORR_LIM  = (ONE + 64'd100) / 64'd200;
    localparam logic [63:0] TARGET_RESET = 64'd2048;

    // Model state and configuration
    logic [FRAC_BITS:0]  ratio_reg;
    logic [QUEUE_BITS-1:0] target_reg;
    logic [63:0]         fill_avg;
    logic [FRAC_BITS:0]  pitch_now;

    // Pitches still owed by the block, oldest first
    logic [FRAC_BITS:0]  pitch_expected[$];

    initial o_mismatches = 0;
    initial o_backlog    = 0;

    // Move value toward goal by trunc((goal - value) * dt / (tau + dt))
    function automatic logic [63:0] glide(input logic [63:0] value, input logic [63:0] goal,
                                          input logic [63:0] dt, input logic [63:0] tau);
        logic [63:0] den;
        den = tau + dt;
        if (goal >= value)
            return value + ((goal - value) * dt) / den;
        return value - ((value - goal) * dt) / den;
    endfunction

    // A zero target behaves as one sample
    function automatic logic [63:0] target_eff();
        return (target_reg == '0) ? 64'd1 : 64'(target_reg);
    endfunction

    task automatic reload_filters();
        fill_avg  = target_eff() << FILL_FRAC;
        pitch_now = ratio_reg;
    endtask

    // Advance both filters by one update and return the new pitch
    task automatic advance_pitch(input logic [QUEUE_BITS-1:0] fill,
                                 input logic [ELAP_W-1:0] elapsed,
                                 output logic [FRAC_BITS:0] pitch);
        logic [63:0] dt;
        logic [63:0] t;
        logic [63:0] tfx;
        logic [63:0] gap;
        logic [63:0] corr;
        logic [63:0] factor;
        logic [63:0] desired;
        logic [63:0] moved;
        logic        below;
        dt  = (64'(elapsed) > 64'(DT_MAX)) ? 64'(DT_MAX) : 64'(elapsed);
        t   = target_eff();
        tfx = t << FILL_FRAC;
        fill_avg = glide(fill_avg, 64'(fill) << FILL_FRAC, dt, 64'(FILL_TAU));

        // Drift correction: 1% of relative error, clamped to half a percent
        below = fill_avg < tfx;
        gap   = below ? tfx - fill_avg : fill_avg - tfx;
        if (gap > tfx) begin
            corr = CORR_LIM;
        end else begin
            corr = (gap << UP) / ((64'd100 * t) << DOWN);
            if (corr > CORR_LIM)
                corr = CORR_LIM;
        end
        factor  = below ? ONE - corr : ONE + corr;
        desired = (64'(ratio_reg) * factor + (ONE >> 1)) >> FRAC_BITS;
        if (desired > PITCH_MAX)
            desired = PITCH_MAX;

        moved     = glide(64'(pitch_now), desired, dt, 64'(PITCH_TAU));
        pitch_now = moved[FRAC_BITS:0];
        pitch     = pitch_now;
    endtask

    // Watch config, input and output transactions at each rising edge
    always @(posedge i_clk) begin
        logic [FRAC_BITS:0] want;
        if (!i_rst_n) begin
            ratio_reg  = ONE[FRAC_BITS:0];
            target_reg = TARGET_RESET[QUEUE_BITS-1:0];
            reload_filters();
            pitch_expected.delete();
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    CFG_RATE_RATIO: begin
                        ratio_reg = i_cfg_wdata[FRAC_BITS:0];
                        reload_filters();
                    end
                    CFG_QUEUE_TARGET: begin
                        target_reg = i_cfg_wdata[QUEUE_BITS-1:0];
                        reload_filters();
                    end
                    default: begin
                    end
                endcase
            end

            // Compare a delivered pitch with the oldest one owed
            if (i_out_valid && i_out_ready) begin
                if (pitch_expected.size() == 0) begin
                    $display("%0t: pitch %0d delivered, expected none", $time, i_pitch);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    want = pitch_expected.pop_front();
                    if (i_pitch !== want) begin
                        $display("%0t: pitch mismatch, expected %0d, actual %0d",
                                 $time, want, i_pitch);
                        o_mismatches = o_mismatches + 1;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                advance_pitch(i_queue_fill, i_elapsed_us, want);
                pitch_expected.push_back(want);
            end
        end
        o_backlog = pitch_expected.size();
    end

endmodule

// ===== tb/audio_drift_pitch_regulator_core_test.sv =====
// Top of the drift pitch regulator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module audio_drift_pitch_regulator_core_test import adpr_pkg::*;;

    localparam int QB            = 16;
    localparam int FB            = 20;
    localparam int CFG_W         = f_cfg_w(QB, FB);
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 400;
    localparam int SEG_ITEMS     = 105;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    localparam logic [CFG_W-1:0] RATIO_UNITY = CFG_W'(1) << FB;
    localparam logic [CFG_W-1:0] RATIO_MAX   = (CFG_W'(1) << (FB + 1)) - CFG_W'(1);

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_wen    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = '0;
    logic [CFG_W-1:0]     i_cfg_wdata  = '0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_ready;
    logic [QB-1:0]        i_queue_fill = '0;
    logic [ELAP_W-1:0]    i_elapsed_us = '0;
    logic                 o_out_valid;
    logic                 i_out_ready  = 1'b0;
    logic [FB:0]          o_pitch;

    int mismatch_total;
    int backlog;
    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;
    int cycles          = 0;
    logic [QB-1:0] target_now = 16'd2048;

    audio_drift_pitch_regulator_core #(
        .QUEUE_BITS (QB),
        .FRAC_BITS  (FB)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_queue_fill (i_queue_fill),
        .i_elapsed_us (i_elapsed_us),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pitch      (o_pitch)
    );

    adpr_pitch_checker #(
        .QUEUE_BITS (QB),
        .FRAC_BITS  (FB)
    ) pitch_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_queue_fill (i_queue_fill),
        .i_elapsed_us (i_elapsed_us),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_pitch      (o_pitch),
        .o_mismatches (mismatch_total),
        .o_backlog    (backlog)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one update, with an optional random gap first; valid stays high on return
    task automatic send_update(input logic [QB-1:0] fill, input logic [ELAP_W-1:0] elapsed);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_queue_fill <= fill;
        i_elapsed_us <= elapsed;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every owed pitch has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (backlog != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_QUEUE_TARGET)
            target_now = data[QB-1:0];
    endtask

    initial begin
        int               window;
        int               level;
        logic [QB-1:0]    fill;
        logic [ELAP_W-1:0] elapsed;

        // Hold reset, then release it on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        sender_idle_pct = 13;
        recv_idle_pct   = 59;

        // Directed: reset settings, zero time, clamped and all-ones elapsed time
        send_update(16'd2048, 20'd0);
        send_update(16'd2048, 20'd10000);
        send_update(16'd0, 20'd100000);
        send_update(16'hFFFF, 20'd1000000);
        send_update(16'hFFFF, 20'hFFFFF);
        send_update(16'd0, 20'd100001);

        // Directed: largest ratio and target, queue swings end to end
        drain();
        write_reg(CFG_RATE_RATIO, RATIO_MAX);
        write_reg(CFG_QUEUE_TARGET, CFG_W'(16'hFFFF));
        send_update(16'hFFFF, 20'd100000);
        send_update(16'hFFFF, 20'd100000);
        send_update(16'd0, 20'd100000);
        send_update(16'd0, 20'd0);

        // Directed: zero ratio, zero target treated as one
        drain();
        write_reg(CFG_RATE_RATIO, '0);
        write_reg(CFG_QUEUE_TARGET, '0);
        send_update(16'd0, 20'd50000);
        send_update(16'd1, 20'd50000);
        send_update(16'd3, 20'd100000);

        // Directed: unknown indexes ignored, upper target bits dropped
        drain();
        write_reg(CFG_RATE_RATIO, RATIO_UNITY);
        write_reg(CFG_QUEUE_TARGET, 21'h1F_0400);
        write_reg(CFG_IDX_SPARE_A, CFG_W'($urandom));
        write_reg(CFG_IDX_SPARE_B, CFG_W'($urandom));
        send_update(16'h0400, 20'd20000);
        send_update(16'h0401, 20'd20000);
        send_update(16'h0800, 20'd100000);
        send_update(16'h0000, 20'd100000);
        drain();
        write_reg(CFG_QUEUE_TARGET, CFG_W'(1));
        send_update(16'd2, 20'd1);
        send_update(16'd1, 20'd99999);

        // Random: three idle profiles, each cut into segments with fresh settings
        for (int ph = 0; ph < 3; ph++) begin
            sender_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 59 : 0;
            recv_idle_pct   = (ph == 0) ? 59 : (ph == 1) ? 13 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                drain();
                case ($urandom_range(7))
                    0: begin
                        write_reg(CFG_RATE_RATIO, $urandom_range(1) ? RATIO_MAX : '0);
                    end
                    1: begin
                        case ($urandom_range(2))
                            0: write_reg(CFG_QUEUE_TARGET, '0);
                            1: write_reg(CFG_QUEUE_TARGET, CFG_W'(1));
                            default: write_reg(CFG_QUEUE_TARGET, CFG_W'(16'hFFFF));
                        endcase
                    end
                    2: begin
                        write_reg($urandom_range(1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                                  CFG_W'($urandom));
                        write_reg(CFG_RATE_RATIO, CFG_W'($urandom));
                    end
                    3: begin
                        write_reg(CFG_QUEUE_TARGET,
                                  {5'($urandom), 16'($urandom_range(256, 8192))});
                    end
                    default: begin
                        write_reg(CFG_RATE_RATIO,
                                  RATIO_UNITY + CFG_W'($urandom_range(0, 131072)) -
                                  CFG_W'(65536));
                        write_reg(CFG_QUEUE_TARGET, CFG_W'($urandom_range(256, 8192)));
                    end
                endcase

                for (int n = 0; n < SEG_ITEMS; n++) begin
                    // Mostly fills around the target, some anywhere in range
                    if ($urandom_range(9) < 8) begin
                        window = $urandom_range(1) ? 64 : 2048;
                        level  = int'(target_now) + $urandom_range(0, 2 * window) - window;
                        if (level < 0)
                            level = 0;
                        if (level > 65535)
                            level = 65535;
                        fill = QB'(level);
                    end else begin
                        fill = QB'($urandom);
                    end
                    // Mostly callback-sized gaps, some zero, long or arbitrary
                    case ($urandom_range(9))
                        0:       elapsed = '0;
                        1:       elapsed = ELAP_W'($urandom_range(40000, 100000));
                        2:       elapsed = ELAP_W'($urandom);
                        default: elapsed = ELAP_W'($urandom_range(500, 40000));
                    endcase
                    send_update(fill, elapsed);
                end
            end
        end

        // Wait out the last results, then give the verdict
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_total == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
